@@ hw/rtl/keyboard_port_event_responder_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the keyboard port event responder
// Each macro builds one labeled concurrent assertion on clk, disabled in rst.
// ----------------------------------------------------------------------------
`ifndef KEYBOARD_PORT_EVENT_RESPONDER_ASSERT_SVH
`define KEYBOARD_PORT_EVENT_RESPONDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KPER_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KPER_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/kper_pkg.sv @@
// ----------------------------------------------------------------------------
// kper_pkg
// Shared types and constants of the keyboard port event responder.
// ----------------------------------------------------------------------------
package kper_pkg;

  // Item kinds.
  localparam logic [1:0] KIND_KEY      = 2'd0;
  localparam logic [1:0] KIND_BUS      = 2'd1;
  localparam logic [1:0] KIND_DESELECT = 2'd2;

  localparam int NUM_KEYS = 256;
  localparam int EVENT_W  = 9;

  // Bus bytes and set-2 scan code bytes.
  localparam logic [7:0] BYTE_IDLE     = 8'hFF;
  localparam logic [7:0] BYTE_ID       = 8'h96;
  localparam logic [7:0] BYTE_MARK     = 8'h5A;
  localparam logic [7:0] BYTE_EXT      = 8'hE0;
  localparam logic [7:0] BYTE_BREAK    = 8'hF0;
  localparam logic [7:0] CMD_SELECT    = 8'h01;
  localparam logic [7:0] CMD_POLL      = 8'h42;

  localparam logic [3:0] FRAME_LAST = 4'd14;

  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic       data;
  } map_wr_t;

  typedef struct packed {
    logic               push;
    logic [EVENT_W-1:0] push_data;
    logic               pop;
  } fifo_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_sts_t;

endpackage

@@ hw/rtl/kper_item_if.sv @@
// ----------------------------------------------------------------------------
// kper_item_if
// Input channel: one key change, bus byte or deselect item per handshake.
// ----------------------------------------------------------------------------
interface kper_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] key_code;
  logic       key_pressed;
  logic [7:0] bus_byte;

  modport source (output valid, kind, key_code, key_pressed, bus_byte, input ready);
  modport sink   (input valid, kind, key_code, key_pressed, bus_byte, output ready);
endinterface

@@ hw/rtl/kper_result_if.sv @@
// ----------------------------------------------------------------------------
// kper_result_if
// Output channel: the reply byte and acknowledge of one bus exchange.
// ----------------------------------------------------------------------------
interface kper_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       ack;

  modport source (output valid, tx_byte, ack, input ready);
  modport sink   (input valid, tx_byte, ack, output ready);
endinterface

@@ hw/rtl/keyboard_port_event_responder.sv @@
// ----------------------------------------------------------------------------
// keyboard_port_event_responder: a bus item's reply passes the stage 1 and output registers.
// Throughput one item per cycle; input stalls only while a reply waits untaken.
// Reset clears control state at once; no clearing pass (map has written bits).
// ----------------------------------------------------------------------------
`include "keyboard_port_event_responder_assert.svh"

// Structure
//   Stage 0 is the input handshake itself. An accepted item issues its read of
//   the key-down map RAM at that edge and lands in the stage 1 register.
//   Stage 1 holds one item together with the map bit that it read. Every item
//   is finished in stage 1, strictly in order, so that the event queue count
//   seen by a poll command includes every key change accepted before it.
//   A bus item in stage 1 writes its reply into the output register; it waits
//   there only when that register still holds a reply the host has not taken.
//
// Key items
//   A key item compares the stored bit with its own state. On a real press or
//   release edge it writes the map and pushes {pressed, code} into the event
//   queue; the queue drops the event when it is full.
//
// Bus items
//   Idle answers FF and moves to selected on a select command. Selected
//   answers FF until a poll command, which pops one event (if any) and answers
//   96 with ack. The popped event is read into the queue RAM's output register
//   always in time for the frame byte that needs it (the length byte at
//   index 3), and it stays on the RAM read port until the next poll. Each
//   further byte advances the frame index; the byte at the last index is sent
//   without ack and the port returns to idle. A deselect item returns to idle.
module keyboard_port_event_responder #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  kper_item_if.sink            item,
  kper_result_if.source        result
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SELECTED,
    PH_RESPONDING
  } phase_t;

  // Stage 1 register.
  logic       s1_valid;
  logic [1:0] s1_kind;
  logic [7:0] s1_code;
  logic       s1_pressed;
  logic [7:0] s1_byte;
  logic       s1_retire;
  logic       accept;

  // Port machine and output register.
  phase_t     phase;
  phase_t     phase_next;
  logic [3:0] frame_index;
  logic [3:0] frame_index_next;
  logic       has_ev;
  logic       has_ev_next;
  logic       out_valid;
  logic [7:0] tx_byte;
  logic [7:0] tx_byte_next;
  logic       ack;
  logic       ack_next;
  logic [3:0] step_index;

  // Links to the map and the queue.
  logic                           old_bit;
  kper_pkg::map_wr_t              map_wr;
  kper_pkg::fifo_ctl_t            fifo_ctl;
  kper_pkg::fifo_sts_t            fifo_sts;
  logic [kper_pkg::EVENT_W-1:0]   ev;

  // Byte of the reply frame at a given index, built from the popped event.
  function automatic logic [7:0] frame_byte(
    input logic [3:0]                   idx,
    input logic                         present,
    input logic [kper_pkg::EVENT_W-1:0] evt
  );
    logic       ext;
    logic       down;
    logic [7:0] code;
    logic [1:0] len;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    ext  = evt[7];
    down = evt[8];
    code = {1'b0, evt[6:0]};
    len  = 2'd1 + {1'b0, ext} + {1'b0, ~down};
    if (ext) begin
      b0 = kper_pkg::BYTE_EXT;
      b1 = down ? code : kper_pkg::BYTE_BREAK;
      b2 = down ? 8'h00 : code;
    end else begin
      b0 = down ? code : kper_pkg::BYTE_BREAK;
      b1 = down ? 8'h00 : code;
      b2 = 8'h00;
    end
    case (idx)
      4'd1:    frame_byte = kper_pkg::BYTE_ID;
      4'd2:    frame_byte = kper_pkg::BYTE_MARK;
      4'd3:    frame_byte = present ? {6'd0, len} : 8'h00;
      4'd4:    frame_byte = present ? b0 : 8'h00;
      4'd5:    frame_byte = present ? b1 : 8'h00;
      4'd6:    frame_byte = present ? b2 : 8'h00;
      default: frame_byte = 8'h00;
    endcase
  endfunction

  // Handshake. Only a bus item can hold stage 1, and only behind a full
  // output register that the host is not draining.
  assign s1_retire = s1_valid &&
                     (s1_kind != kper_pkg::KIND_BUS || !out_valid || result.ready);
  assign item.ready = !s1_valid || s1_retire;
  assign accept     = item.valid && item.ready;

  assign result.valid   = out_valid;
  assign result.tx_byte = tx_byte;
  assign result.ack     = ack;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_retire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind    <= item.kind;
      s1_code    <= item.key_code;
      s1_pressed <= item.key_pressed;
      s1_byte    <= item.bus_byte;
    end
  end

  kper_key_map u_key_map (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .rd_addr(item.key_code),
    .wr     (map_wr),
    .old_bit(old_bit)
  );

  kper_event_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_event_fifo (
    .clk  (clk),
    .rst  (rst),
    .ctl  (fifo_ctl),
    .sts  (fifo_sts),
    .rdata(ev)
  );

  // Key change: write the map and queue the edge.
  always_comb begin
    map_wr.en   = s1_valid && s1_kind == kper_pkg::KIND_KEY && (old_bit != s1_pressed);
    map_wr.addr = s1_code;
    map_wr.data = s1_pressed;

    fifo_ctl.push      = map_wr.en;
    fifo_ctl.push_data = {s1_pressed, s1_code};
    fifo_ctl.pop       = s1_retire && s1_kind == kper_pkg::KIND_BUS &&
                         phase == PH_SELECTED && s1_byte == kper_pkg::CMD_POLL &&
                         !fifo_sts.empty;
  end

  // Port machine for the item in stage 1.
  always_comb begin
    phase_next       = phase;
    frame_index_next = frame_index;
    has_ev_next      = has_ev;
    tx_byte_next     = kper_pkg::BYTE_IDLE;
    ack_next         = 1'b0;
    step_index       = (frame_index < kper_pkg::FRAME_LAST) ?
                       frame_index + 4'd1 : frame_index;
    case (s1_kind)
      kper_pkg::KIND_BUS: begin
        case (phase)
          PH_SELECTED: begin
            if (s1_byte == kper_pkg::CMD_POLL) begin
              has_ev_next      = !fifo_sts.empty;
              frame_index_next = 4'd1;
              tx_byte_next     = kper_pkg::BYTE_ID;
              ack_next         = 1'b1;
              phase_next       = PH_RESPONDING;
            end
          end
          PH_RESPONDING: begin
            frame_index_next = step_index;
            tx_byte_next     = frame_byte(step_index, has_ev, ev);
            if (step_index >= kper_pkg::FRAME_LAST) begin
              phase_next = PH_IDLE;
            end else begin
              ack_next = 1'b1;
            end
          end
          default: begin
            phase_next = PH_IDLE;
            if (s1_byte == kper_pkg::CMD_SELECT) begin
              phase_next = PH_SELECTED;
              ack_next   = 1'b1;
            end
          end
        endcase
      end
      kper_pkg::KIND_DESELECT: begin
        phase_next       = PH_IDLE;
        frame_index_next = 4'd0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      frame_index <= 4'd0;
      has_ev      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (s1_retire) begin
        phase       <= phase_next;
        frame_index <= frame_index_next;
        has_ev      <= has_ev_next;
      end
      if (s1_retire && s1_kind == kper_pkg::KIND_BUS) begin
        out_valid <= 1'b1;
        tx_byte   <= tx_byte_next;
        ack       <= ack_next;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A stalled input always traces back to a waiting reply.
  `KPER_ASSERT_NOW(a_stall_cause, !item.ready, s1_valid && s1_kind == kper_pkg::KIND_BUS && out_valid && !result.ready, "input stalled without a waiting reply")
  // A pop happens only when a frame starts, and that frame carries an event.
  `KPER_ASSERT_NEXT(a_pop_starts_frame, fifo_ctl.pop, phase == PH_RESPONDING && frame_index == 4'd1 && has_ev, "event popped outside frame start")
  // While responding the frame index stays strictly inside the frame.
  `KPER_ASSERT_NOW(a_resp_index, phase == PH_RESPONDING, frame_index >= 4'd1 && frame_index < kper_pkg::FRAME_LAST, "frame index out of range while responding")

endmodule

@@ hw/rtl/kper_ram.sv @@
// ----------------------------------------------------------------------------
// kper_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module kper_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/kper_key_map.sv @@
// ----------------------------------------------------------------------------
// kper_key_map
// Key-down map in RAM with per-key written bits and one-deep write forwarding.
// ----------------------------------------------------------------------------
module kper_key_map (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [7:0]        rd_addr,
  input  kper_pkg::map_wr_t wr,
  output logic              old_bit
);

  logic [kper_pkg::NUM_KEYS-1:0] written;
  logic                          rdata;
  logic [7:0]                    addr_q;
  logic                          vld_q;
  logic                          fwd_en;
  logic [7:0]                    fwd_addr;
  logic                          fwd_data;

  kper_ram #(
    .WIDTH(1),
    .DEPTH(kper_pkg::NUM_KEYS)
  ) u_map_ram (
    .clk  (clk),
    .we   (wr.en),
    .waddr(wr.addr),
    .wdata(wr.data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  // The read is issued at the same edge as the previous item's write, so that
  // write is forwarded; a key never written reads as up.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      fwd_en  <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        fwd_en <= wr.en;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      addr_q   <= rd_addr;
      vld_q    <= written[rd_addr];
      fwd_addr <= wr.addr;
      fwd_data <= wr.data;
    end
  end

  always_comb begin
    if (fwd_en && fwd_addr == addr_q) begin
      old_bit = fwd_data;
    end else begin
      old_bit = vld_q & rdata;
    end
  end

endmodule

@@ hw/rtl/kper_event_fifo.sv @@
// ----------------------------------------------------------------------------
// kper_event_fifo
// Key event queue in RAM; pushes into a full queue are dropped.
// ----------------------------------------------------------------------------
module kper_event_fifo #(
  parameter int DEPTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  kper_pkg::fifo_ctl_t            ctl,
  output kper_pkg::fifo_sts_t            sts,
  output logic [kper_pkg::EVENT_W-1:0]   rdata
);

  localparam int AW = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [CW:0]   sum;
  logic [AW-1:0] tail;
  logic          push_ok;
  logic          pop_ok;

  assign sts.empty = (count == '0);
  assign sts.full  = (count == CW'(DEPTH));
  assign push_ok   = ctl.push && !sts.full;
  assign pop_ok    = ctl.pop && !sts.empty;

  // head + count stays below twice the depth, so one subtract wraps it.
  always_comb begin
    sum = (CW + 1)'(head) + (CW + 1)'(count);
    if (sum >= (CW + 1)'(DEPTH)) begin
      tail = AW'(sum - (CW + 1)'(DEPTH));
    end else begin
      tail = AW'(sum);
    end
  end

  kper_ram #(
    .WIDTH(kper_pkg::EVENT_W),
    .DEPTH(DEPTH)
  ) u_fifo_ram (
    .clk  (clk),
    .we   (push_ok),
    .waddr(tail),
    .wdata(ctl.push_data),
    .re   (pop_ok),
    .raddr(head),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      if (push_ok) begin
        count <= count + 1'b1;
      end else if (pop_ok) begin
        count <= count - 1'b1;
        if (head == AW'(DEPTH - 1)) begin
          head <= '0;
        end else begin
          head <= head + 1'b1;
        end
      end
    end
  end

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// Keyboard port event responder testbench
// Drives key changes, bus bytes and deselects through the item channel and
// checks every reply byte and acknowledge against a predictor of the block or a typed row.
// The run opens with a short table of directed items, then moves on to
// random traffic built mostly from well-formed poll sequences.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import kper_pkg::*;

  localparam int EVENT_DEPTH = 32;
  localparam int TOTAL_ITEMS = 1350;
  localparam int HOLD_CYCLES = 60;
  localparam int N_DIRECTED  = 25;

  // The unused kind value; the block must ignore such items.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Frame bytes that follow the poll command: indices 2 through FRAME_LAST.
  localparam int FRAME_TAIL = int'(FRAME_LAST) - 1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SELECTED,
    PH_RESPONDING
  } port_phase_e;

  typedef struct packed {
    logic [7:0] tx;
    logic       ack;
  } reply_t;

  // One row of the directed table. Where typed is set, the reply is written
  // in the row itself; otherwise the predictor supplies it.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] code;
    logic       pressed;
    logic [7:0] rx;
    logic       typed;
    logic [7:0] tx;
    logic       ack;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  kper_item_if   item_bus ();
  kper_result_if reply_bus ();

  keyboard_port_event_responder #(
    .QUEUE_DEPTH(EVENT_DEPTH)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_bus),
    .result(reply_bus)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Side-band copy of the typed reply that travels with the item on offer.
  logic       drv_typed;
  logic [7:0] drv_tx;
  logic       drv_ack;

  // --------------------------------------------------------------------------
  // Predictor state: its own copy of the key map, event queue and port machine.
  // --------------------------------------------------------------------------
  bit          key_map [NUM_KEYS];
  logic [8:0]  key_events [$];
  port_phase_e phase = PH_IDLE;
  logic [7:0]  frame [15];
  logic [3:0]  frame_idx = '0;

  reply_t pending_replies [$];

  int fails = 0;
  int checked = 0;
  int items_sent = 0;
  int n_keys = 0;
  int n_bus = 0;
  int n_queued = 0;
  int n_dropped = 0;
  int n_frames = 0;
  int n_loaded_frames = 0;
  int n_holds = 0;
  int n_drains = 0;

  int burst_left = 0;
  bit back_to_back = 1'b0;
  bit hold_req = 1'b0;

  // Works out what the block answers to one item and advances the predictor
  // state. Returns 1 when the item causes a reply.
  function automatic bit predict_port_reply(input logic [1:0] kind,
                                            input logic [7:0] code,
                                            input logic pressed,
                                            input logic [7:0] rx,
                                            output reply_t rep);
    logic [8:0] ev;
    int n;
    rep = '0;
    predict_port_reply = 1'b0;
    case (kind)
      KIND_KEY: begin
        n_keys++;
        // Only a real press or release edge becomes an event. On a full
        // queue the event is lost but the map still follows the key.
        if (key_map[code] != pressed) begin
          key_map[code] = pressed;
          if (key_events.size() < EVENT_DEPTH) begin
            key_events.push_back({pressed, code});
            n_queued++;
          end else begin
            n_dropped++;
          end
        end
      end
      KIND_DESELECT: begin
        phase = PH_IDLE;
        frame_idx = '0;
      end
      KIND_BUS: begin
        n_bus++;
        predict_port_reply = 1'b1;
        case (phase)
          PH_SELECTED: begin
            if (rx == CMD_POLL) begin
              // Build the whole frame now; at most one event goes into it.
              for (int i = 0; i < 15; i++) frame[i] = 8'h00;
              frame[0] = BYTE_IDLE;
              frame[1] = BYTE_ID;
              frame[2] = BYTE_MARK;
              n_frames++;
              if (key_events.size() != 0) begin
                ev = key_events.pop_front();
                n = 0;
                if (ev[7]) begin
                  frame[4 + n] = BYTE_EXT;
                  n++;
                end
                if (!ev[8]) begin
                  frame[4 + n] = BYTE_BREAK;
                  n++;
                end
                frame[4 + n] = {1'b0, ev[6:0]};
                n++;
                frame[3] = n[7:0];
                n_loaded_frames++;
              end
              frame_idx = 4'd1;
              rep.tx = frame[1];
              rep.ack = 1'b1;
              phase = PH_RESPONDING;
            end else begin
              rep.tx = BYTE_IDLE;
            end
          end
          PH_RESPONDING: begin
            // The host's byte is ignored while the frame goes out.
            if (frame_idx < FRAME_LAST) frame_idx++;
            rep.tx = frame[frame_idx];
            if (frame_idx >= FRAME_LAST) begin
              phase = PH_IDLE;
            end else begin
              rep.ack = 1'b1;
            end
          end
          default: begin
            phase = PH_IDLE;
            rep.tx = BYTE_IDLE;
            if (rx == CMD_SELECT) begin
              phase = PH_SELECTED;
              rep.ack = 1'b1;
            end
          end
        endcase
      end
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard. Both channels are sampled at the rising edge, before any of
  // this edge's updates land, so the values seen are the ones that handshook.
  // The reply check runs first: a reply taken at this edge always belongs to
  // an item accepted at an earlier edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    reply_t seen;
    reply_t want;
    reply_t pred;
    if (!rst) begin
      if (reply_bus.valid && reply_bus.ready) begin
        seen.tx = reply_bus.tx_byte;
        seen.ack = reply_bus.ack;
        if (pending_replies.size() == 0) begin
          if (fails < 10)
            $display("unexpected reply: tx_byte=%h ack=%b", seen.tx, seen.ack);
          fails++;
        end else begin
          want = pending_replies.pop_front();
          checked++;
          if (seen.tx !== want.tx || seen.ack !== want.ack) begin
            if (fails < 10)
              $display("reply %0d mismatch: tx_byte exp %h got %h, ack exp %b got %b",
                       checked, want.tx, seen.tx, want.ack, seen.ack);
            fails++;
          end
        end
      end
      if (item_bus.valid && item_bus.ready) begin
        if (predict_port_reply(item_bus.kind, item_bus.key_code, item_bus.key_pressed,
                               item_bus.bus_byte, pred)) begin
          if (drv_typed) begin
            want.tx = drv_tx;
            want.ack = drv_ack;
          end else begin
            want = pred;
          end
          pending_replies.push_back(want);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender. Items go out in bursts of random length; between bursts the valid
  // line drops for a random gap, and some bursts follow with no gap at all.
  // Valid is only lowered when a real gap follows, so it never sees a low and
  // a high assignment at the same edge.
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] kind, input logic [7:0] code,
                           input logic pressed, input logic [7:0] rx,
                           input logic typed, input logic [7:0] tx, input logic ack);
    int gap;
    if (burst_left == 0) begin
      gap = (back_to_back || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        item_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    item_bus.valid       <= 1'b1;
    item_bus.kind        <= kind;
    item_bus.key_code    <= code;
    item_bus.key_pressed <= pressed;
    item_bus.bus_byte    <= rx;
    drv_typed            <= typed;
    drv_tx               <= tx;
    drv_ack              <= ack;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    burst_left--;
    if (kind != KIND_UNUSED) items_sent++;
  endtask

  // A bus byte with noise on the fields that a bus item does not use.
  task automatic send_bus(input logic [7:0] rx);
    send_item(KIND_BUS, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), rx,
              1'b0, 8'h00, 1'b0);
  endtask

  // Select, poll, then clock out the rest of the frame with random host bytes.
  task automatic send_full_poll();
    send_bus(CMD_SELECT);
    send_bus(CMD_POLL);
    repeat (FRAME_TAIL) send_bus(8'($urandom_range(0, 255)));
  endtask

  // Stops offering items until every expected reply has come back or the bound
  // is reached, then idles on before returning. The first edge
  // lets the scoreboard record the item that was just handed over.
  task automatic drain_replies(input int bound);
    int waited;
    waited = 0;
    if (item_bus.valid) item_bus.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_replies.size() != 0 && waited < bound) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  // Directed table: states after reset, the select and poll commands, an
  // empty frame, key edges of both kinds, an unchanged key, the unused kind,
  // and a deselect in the middle of a frame.
  stim_row_t directed [N_DIRECTED] = '{
    // Idle: any byte but select is answered FF without acknowledge.
    '{KIND_BUS,      8'h00, 1'b0, 8'h00,      1'b1, BYTE_IDLE, 1'b0},
    '{KIND_BUS,      8'hFF, 1'b1, 8'hFF,      1'b1, BYTE_IDLE, 1'b0},
    '{KIND_BUS,      8'h00, 1'b0, CMD_SELECT, 1'b1, BYTE_IDLE, 1'b1},
    // Selected: a byte other than poll keeps the port selected.
    '{KIND_BUS,      8'h00, 1'b0, 8'h00,      1'b1, BYTE_IDLE, 1'b0},
    // Poll with an empty queue gives a frame of length zero.
    '{KIND_BUS,      8'h00, 1'b0, CMD_POLL,   1'b1, BYTE_ID,   1'b1},
    '{KIND_BUS,      8'h00, 1'b0, 8'hFF,      1'b1, BYTE_MARK, 1'b1},
    '{KIND_BUS,      8'h00, 1'b0, 8'h00,      1'b1, 8'h00,     1'b1},
    '{KIND_DESELECT, 8'h00, 1'b0, 8'h00,      1'b0, 8'h00,     1'b0},
    // Key edges: lowest code pressed, highest (extended) code pressed, a repeat of
    // the same state, a release of a key that is already up, then the highest code released.
    '{KIND_KEY,      8'h00, 1'b1, 8'hFF,      1'b0, 8'h00,     1'b0},
    '{KIND_KEY,      8'hFF, 1'b1, 8'h00,      1'b0, 8'h00,     1'b0},
    '{KIND_KEY,      8'hFF, 1'b1, 8'h00,      1'b0, 8'h00,     1'b0},
    '{KIND_KEY,      8'h80, 1'b0, 8'h00,      1'b0, 8'h00,     1'b0},
    '{KIND_KEY,      8'hFF, 1'b0, 8'hFF,      1'b0, 8'h00,     1'b0},
    // The unused kind carries a select byte that must have no effect.
    '{KIND_UNUSED,   8'hFF, 1'b1, CMD_SELECT, 1'b0, 8'h00,     1'b0},
    '{KIND_BUS,      8'h00, 1'b0, CMD_POLL,   1'b1, BYTE_IDLE, 1'b0},
    '{KIND_BUS,      8'hFF, 1'b1, CMD_SELECT, 1'b1, BYTE_IDLE, 1'b1},
    '{KIND_BUS,      8'h00, 1'b0, CMD_POLL,   1'b1, BYTE_ID,   1'b1},
    '{KIND_BUS,      8'h00, 1'b0, 8'h00,      1'b1, BYTE_MARK, 1'b1},
    '{KIND_BUS,      8'h00, 1'b0, 8'hAA,      1'b0, 8'h00,     1'b0},
    '{KIND_BUS,      8'h00, 1'b0, 8'h55,      1'b0, 8'h00,     1'b0},
    // Deselect in the middle of the frame.
    '{KIND_DESELECT, 8'hFF, 1'b1, 8'hFF,      1'b0, 8'h00,     1'b0},
    '{KIND_BUS,      8'h00, 1'b0, CMD_SELECT, 1'b1, BYTE_IDLE, 1'b1},
    '{KIND_BUS,      8'h00, 1'b0, CMD_POLL,   1'b1, BYTE_ID,   1'b1},
    '{KIND_BUS,      8'h00, 1'b0, 8'h00,      1'b1, BYTE_MARK, 1'b1},
    '{KIND_BUS,      8'h00, 1'b0, 8'h00,      1'b0, 8'h00,     1'b0}
  };

  // --------------------------------------------------------------------------
  // Stimulus: reset, the directed table, then random sequences until the item
  // count is reached. Every few hundred items the receiver is held off while
  // the sender keeps offering, or the sender waits for all replies.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int next_pressure;
    bit hold_turn;
    int pick;
    int key_share;
    bit narrow;
    logic [7:0] code;
    rst                  = 1'b1;
    item_bus.valid       = 1'b0;
    item_bus.kind        = KIND_KEY;
    item_bus.key_code    = 8'h00;
    item_bus.key_pressed = 1'b0;
    item_bus.bus_byte    = 8'h00;
    drv_typed            = 1'b0;
    drv_tx               = 8'h00;
    drv_ack              = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      send_item(directed[i].kind, directed[i].code, directed[i].pressed, directed[i].rx,
                directed[i].typed, directed[i].tx, directed[i].ack);

    next_pressure = 150;
    hold_turn = 1'b1;
    while (items_sent < TOTAL_ITEMS) begin
      if (items_sent >= next_pressure) begin
        if (hold_turn) begin
          // The receiver stops for a long stretch while polls keep coming,
          // so the reply path fills and the item channel has to stall.
          hold_req = 1'b1;
          back_to_back = 1'b1;
          send_full_poll();
          send_full_poll();
          back_to_back = 1'b0;
          n_holds++;
        end else begin
          drain_replies(20000);
          n_drains++;
        end
        hold_turn = !hold_turn;
        next_pressure += 300;
      end

      // Alternate eras: key-heavy ones keep the queue full and dropping,
      // light ones let polls empty it and send frames of length zero.
      key_share = ((items_sent / 400) % 2 != 0) ? 8 : 32;
      pick = $urandom_range(0, 99);
      if (pick < key_share) begin
        // Key storm; the narrow form reuses a few codes, both halves of bit 7.
        narrow = 1'($urandom_range(0, 1));
        repeat ($urandom_range(1, 40)) begin
          code = 8'($urandom_range(0, 255));
          if (narrow) code = code & 8'h83;
          send_item(KIND_KEY, code, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                    1'b0, 8'h00, 1'b0);
        end
      end else if (pick < 70) begin
        send_full_poll();
        repeat ($urandom_range(0, 2)) send_bus(8'($urandom_range(0, 255)));
      end else if (pick < 82) begin
        // Frame cut short by a deselect.
        send_bus(CMD_SELECT);
        send_bus(CMD_POLL);
        repeat ($urandom_range(0, FRAME_TAIL - 1)) send_bus(8'($urandom_range(0, 255)));
        send_item(KIND_DESELECT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)), 1'b0, 8'h00, 1'b0);
      end else if (pick < 92) begin
        // Select followed by bytes that are mostly not a poll.
        send_bus(CMD_SELECT);
        repeat ($urandom_range(1, 4)) send_bus(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) != 0)
          send_item(KIND_DESELECT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    8'($urandom_range(0, 255)), 1'b0, 8'h00, 1'b0);
      end else begin
        // Noise: any kind, the unused one included, with random fields.
        repeat ($urandom_range(1, 5))
          send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                    1'b0, 8'h00, 1'b0);
      end
    end

    drain_replies(20000);
    repeat (8) @(posedge clk);
    if (pending_replies.size() != 0) begin
      if (fails < 10)
        $display("%0d expected replies never arrived", pending_replies.size());
      fails += pending_replies.size();
    end

    $display("Ran %0d items: %0d key changes, %0d bus bytes, %0d replies checked.",
             items_sent, n_keys, n_bus, checked);
    $display("Queued %0d events, dropped %0d; %0d frames (%0d loaded), %0d holds, %0d drains.",
             n_queued, n_dropped, n_frames, n_loaded_frames, n_holds, n_drains);
    if (fails == 0) begin
      $display("[keyboard_port_event_responder] OK");
    end else begin
      $display("%0d failures", fails);
      $display("[keyboard_port_event_responder] ERROR");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver. It changes its stall pattern every so often: always ready,
  // random, a fixed one-in-four stall, or mostly stalled. A hold request from
  // the sender side drops ready for a long stretch counted here.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int mode;
    int mode_left;
    int tick;
    mode = 0;
    mode_left = 0;
    tick = 0;
    reply_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_req) begin
        hold_req = 1'b0;
        reply_bus.ready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(50, 200);
        end
        mode_left--;
        case (mode)
          0: reply_bus.ready <= 1'b1;
          1: reply_bus.ready <= 1'($urandom_range(0, 1));
          2: reply_bus.ready <= (tick % 4 != 0);
          default: reply_bus.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Hard stop well beyond the slowest correct run.
  initial begin : watchdog
    #2000000;
    $display("timeout with %0d replies outstanding", pending_replies.size());
    $display("[keyboard_port_event_responder] ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/kper_pkg.sv
hw/rtl/kper_item_if.sv
hw/rtl/kper_result_if.sv
hw/rtl/kper_ram.sv
hw/rtl/kper_key_map.sv
hw/rtl/kper_event_fifo.sv
hw/rtl/keyboard_port_event_responder.sv
dv/testbench.sv
